### sv/fqt_pkg.sv
// Shared types, codes, character constants and hex helper for the form/query token decoder.
`default_nettype none

package fqt_pkg;

   localparam int MAX_RES       = 4;     // most results one transaction can cause
   localparam int RES_CNT_W     = 3;     // holds 0..MAX_RES
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 12;
   localparam int MAX_LEN_RESET = 4095;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COOKIE_MODE   = 2'd0,
      CSR_STOP_MODE     = 2'd1,
      CSR_MAX_TOKEN_LEN = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_DATA      = 3'd0,
      KIND_KEY_END   = 3'd1,
      KIND_VALUE_END = 3'd2,
      KIND_ENTRY_END = 3'd3,
      KIND_OVERFLOW  = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ESC_NONE    = 2'd0,
      ESC_PERCENT = 2'd1,
      ESC_DIGIT   = 2'd2
   } esc_phase_type;

   typedef struct packed {
      logic          in_value;
      esc_phase_type phase;
      logic [3:0]    value;
      logic [7:0]    first_char;
   } parse_state_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       in_value;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_DIG_0   = 8'h30;
   localparam logic [7:0] CH_DIG_9   = 8'h39;
   localparam logic [7:0] CH_UP_A    = 8'h41;
   localparam logic [7:0] CH_UP_F    = 8'h46;
   localparam logic [7:0] CH_LOW_A   = 8'h61;
   localparam logic [7:0] CH_LOW_F   = 8'h66;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h = '0;
      if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
         h.ok    = 1'b1;
         h.value = 4'(c - CH_DIG_0);
      end else if (c >= CH_UP_A && c <= CH_UP_F) begin
         h.ok    = 1'b1;
         h.value = 4'(c - CH_UP_A + 8'd10);
      end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
         h.ok    = 1'b1;
         h.value = 4'(c - CH_LOW_A + 8'd10);
      end
      return h;
   endfunction

endpackage

`default_nettype wire

### sv/fqt_if.sv
// Request and response channel interfaces of the form/query token decoder.
`default_nettype none

interface fqt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source(output valid, output in_byte, output end_of_input, input ready);
   modport sink(input valid, input in_byte, input end_of_input, output ready);
endinterface

interface fqt_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] item_kind;
   logic [7:0] data_byte;
   logic       in_value;
   logic       last;

   modport source(output valid, output item_kind, output data_byte, output in_value,
                  output last, input ready);
   modport sink(input valid, input item_kind, input data_byte, input in_value,
                input last, output ready);
endinterface

`default_nettype wire

### sv/fqt_decode.sv
// Per-byte decode: parse state and one raw byte in, next state and up to four results out.
`default_nettype none

module fqt_decode #(
   parameter int CNT_W = 12
) (
   input  logic [7:0]                 in_byte,
   input  logic                       end_of_input,
   input  logic                       cookie_mode,
   input  logic                       stop_mode,
   input  logic [CNT_W-1:0]           limit,
   input  fqt_pkg::parse_state_type   st,
   input  logic [CNT_W-1:0]           count,
   output fqt_pkg::parse_state_type   st_next,
   output logic [CNT_W-1:0]           count_next,
   output fqt_pkg::result_type        res [fqt_pkg::MAX_RES],
   output logic [fqt_pkg::RES_CNT_W-1:0] res_cnt
);

   always_comb begin : decode
      fqt_pkg::hex_type         hx;
      fqt_pkg::parse_state_type s;
      fqt_pkg::kind_type        end_kind;
      logic [CNT_W-1:0]         cnt;
      logic [fqt_pkg::RES_CNT_W-1:0] n;
      logic                     bad;
      logic                     do_put;
      logic                     do_end;
      logic                     end_iv;
      logic [7:0]               pb;

      hx       = fqt_pkg::hex_decode(in_byte);
      s        = st;
      cnt      = count;
      n        = '0;
      do_put   = 1'b0;
      do_end   = 1'b0;
      end_iv   = 1'b0;
      end_kind = fqt_pkg::KIND_ENTRY_END;
      pb       = in_byte;
      for (int i = 0; i < fqt_pkg::MAX_RES; i++) begin
         res[i] = '0;
      end

      // broken escape: emit '%' and possibly the held digit
      bad = (st.phase != fqt_pkg::ESC_NONE) && (end_of_input || !hx.ok);
      if (bad) begin
         if (cnt >= limit) begin
            res[n[1:0]] = '{kind: fqt_pkg::KIND_OVERFLOW, data: 8'h00, in_value: s.in_value};
            n   = n + 1'b1;
            cnt = '0;
         end
         res[n[1:0]] = '{kind: fqt_pkg::KIND_DATA, data: fqt_pkg::CH_PERCENT,
                         in_value: s.in_value};
         n   = n + 1'b1;
         cnt = cnt + CNT_W'(1);
         if (st.phase == fqt_pkg::ESC_DIGIT &&
             (CNT_W+1)'(cnt) + (CNT_W+1)'(1) < (CNT_W+1)'(limit)) begin
            res[n[1:0]] = '{kind: fqt_pkg::KIND_DATA, data: st.first_char,
                            in_value: s.in_value};
            n   = n + 1'b1;
            cnt = cnt + CNT_W'(1);
         end
         s.phase      = fqt_pkg::ESC_NONE;
         s.value      = '0;
         s.first_char = '0;
      end

      if (end_of_input) begin
         do_end   = 1'b1;
         end_kind = s.in_value ? fqt_pkg::KIND_VALUE_END : fqt_pkg::KIND_ENTRY_END;
      end else if (st.phase == fqt_pkg::ESC_NONE || bad) begin
         // leading blanks of a cookie key are dropped
         if (!(cookie_mode && !s.in_value && cnt == '0 &&
               (in_byte == fqt_pkg::CH_SPACE || in_byte == fqt_pkg::CH_TAB))) begin
            end_kind = s.in_value ? fqt_pkg::KIND_VALUE_END : fqt_pkg::KIND_ENTRY_END;
            unique case (in_byte) inside
               fqt_pkg::CH_PERCENT: s.phase = fqt_pkg::ESC_PERCENT;
               fqt_pkg::CH_PLUS: begin
                  do_put = 1'b1;
                  pb     = fqt_pkg::CH_SPACE;
               end
               fqt_pkg::CH_AMP: begin
                  do_put = cookie_mode;
                  do_end = !cookie_mode;
               end
               fqt_pkg::CH_SEMI: begin
                  do_put = !cookie_mode;
                  do_end = cookie_mode;
               end
               fqt_pkg::CH_EQUAL: begin
                  do_put = s.in_value;
                  do_end = !s.in_value;
                  end_kind = fqt_pkg::KIND_KEY_END;
                  end_iv   = 1'b1;
               end
               fqt_pkg::CH_CR: begin
                  do_end = stop_mode;
                  do_put = !stop_mode && !cookie_mode;
               end
               fqt_pkg::CH_LF: begin
                  do_end = cookie_mode || stop_mode;
                  do_put = !(cookie_mode || stop_mode);
               end
               fqt_pkg::CH_SPACE, fqt_pkg::CH_TAB: begin
                  do_end = stop_mode;
                  do_put = !stop_mode;
               end
               default: do_put = 1'b1;
            endcase
         end
      end else if (st.phase == fqt_pkg::ESC_PERCENT) begin
         s.phase      = fqt_pkg::ESC_DIGIT;
         s.value      = hx.value;
         s.first_char = in_byte;
      end else begin
         do_put       = 1'b1;
         pb           = {st.value, hx.value};
         s.phase      = fqt_pkg::ESC_NONE;
         s.value      = '0;
         s.first_char = '0;
      end

      if (do_put) begin
         if (cnt >= limit) begin
            res[n[1:0]] = '{kind: fqt_pkg::KIND_OVERFLOW, data: 8'h00, in_value: s.in_value};
            n   = n + 1'b1;
            cnt = '0;
         end
         res[n[1:0]] = '{kind: fqt_pkg::KIND_DATA, data: pb, in_value: s.in_value};
         n   = n + 1'b1;
         cnt = cnt + CNT_W'(1);
      end

      if (do_end) begin
         res[n[1:0]] = '{kind: end_kind, data: 8'h00, in_value: s.in_value};
         n            = n + 1'b1;
         s.in_value   = end_iv;
         cnt          = '0;
         s.phase      = fqt_pkg::ESC_NONE;
         s.value      = '0;
         s.first_char = '0;
      end

      st_next    = s;
      count_next = cnt;
      res_cnt    = n;
   end

endmodule

`default_nettype wire

### sv/fqt_burst.sv
// Burst register: holds one transaction's results and hands out one per cycle while ready.
`default_nettype none

module fqt_burst (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  fqt_pkg::result_type           load_res [fqt_pkg::MAX_RES],
   input  logic [fqt_pkg::RES_CNT_W-1:0] load_cnt,
   output logic                          can_load,
   fqt_rsp_if.source                     rsp_chan
);

   fqt_pkg::result_type           ent_ff [fqt_pkg::MAX_RES];
   fqt_pkg::result_type           ent_in [fqt_pkg::MAX_RES];
   logic [fqt_pkg::RES_CNT_W-1:0] cnt_ff;
   logic [fqt_pkg::RES_CNT_W-1:0] cnt_in;
   logic                          take;

   assign take     = rsp_chan.valid && rsp_chan.ready;
   assign can_load = (cnt_ff == '0) ||
                     (cnt_ff == fqt_pkg::RES_CNT_W'(1) && rsp_chan.ready);

   always_comb begin
      ent_in = ent_ff;
      cnt_in = cnt_ff;
      if (load) begin
         ent_in = load_res;
         cnt_in = load_cnt;
      end else if (take) begin
         for (int i = 0; i < fqt_pkg::MAX_RES - 1; i++) begin
            ent_in[i] = ent_ff[i+1];
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign rsp_chan.valid     = (cnt_ff != '0);
   assign rsp_chan.item_kind = ent_ff[0].kind;
   assign rsp_chan.data_byte = ent_ff[0].data;
   assign rsp_chan.in_value  = ent_ff[0].in_value;
   assign rsp_chan.last      = (cnt_ff == fqt_pkg::RES_CNT_W'(1));

endmodule

`default_nettype wire

### sv/form_query_token_decoder_top.sv
// Top level of the streaming form/query/cookie token decoder.
`default_nettype none

// Streaming decoder for form-encoded query strings and cookie headers. Each req
// transaction carries one raw byte (or an end-of-input mark) and causes zero to four
// rsp transactions: decoded data bytes and key/value/entry end markers, with last set
// on the final one. The block takes one byte per cycle as long as each byte gives at
// most one result and rsp is ready; a byte that gives several results holds the rsp
// side until each has been handed out, so the sustained rate is set by the result
// burst register, which hands out one result per cycle while rsp is ready. A byte
// passes through the input register, then the burst register, before its first rsp.
// There is one transaction of slack: a byte is taken into the input register while
// the previous results still wait on rsp. Bytes that cause no result ('%', a first
// hex digit, a dropped blank) pass through without costing rsp cycles. CSR writes
// (index 0 cookie mode, 1 stop mode that ends input at CR, LF, space or tab, 2
// max_token_len) are meant for idle periods; max_token_len is clamped to TOKEN_MAX,
// and zero acts as one. No memories, so no init sweep after reset.
module form_query_token_decoder_top #(
   parameter int TOKEN_MAX = 4095
) (
   input  logic                           clock,
   input  logic                           reset,
   fqt_req_if.sink                        req_chan,
   fqt_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [fqt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fqt_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W     = $clog2(TOKEN_MAX + 1);
   localparam int LIM_RESET = (TOKEN_MAX < fqt_pkg::MAX_LEN_RESET) ?
                              TOKEN_MAX : fqt_pkg::MAX_LEN_RESET;

   // config
   logic             cookie_ff, cookie_in;
   logic             stop_ff, stop_in;
   logic [CNT_W-1:0] lim_ff, lim_in;
   logic [CNT_W-1:0] lim_wr;

   // input register stage
   logic       a_valid_ff, a_valid_in;
   logic [7:0] a_byte_ff, a_byte_in;
   logic       a_eoi_ff, a_eoi_in;
   logic       a_move;
   logic       req_take;

   // parse state
   fqt_pkg::parse_state_type st_ff, st_in, st_next;
   logic [CNT_W-1:0]         count_ff, count_in, count_next;

   fqt_pkg::result_type           dec_res [fqt_pkg::MAX_RES];
   logic [fqt_pkg::RES_CNT_W-1:0] dec_cnt;
   logic                          can_load;

   // effective token limit, worked out once at write time
   always_comb begin
      if (int'(csr_wdata) > TOKEN_MAX) begin
         lim_wr = CNT_W'(TOKEN_MAX);
      end else if (csr_wdata == '0) begin
         lim_wr = CNT_W'(1);
      end else begin
         lim_wr = CNT_W'(csr_wdata);
      end
   end

   always_comb begin
      cookie_in = cookie_ff;
      stop_in   = stop_ff;
      lim_in    = lim_ff;
      if (csr_we) begin
         unique case (csr_index)
            fqt_pkg::CSR_COOKIE_MODE:   cookie_in = csr_wdata[0];
            fqt_pkg::CSR_STOP_MODE:     stop_in   = csr_wdata[0];
            fqt_pkg::CSR_MAX_TOKEN_LEN: lim_in    = lim_wr;
            default: ;
         endcase
      end
   end

   // A hands its byte to the decoder when the burst register can take the results
   assign a_move         = a_valid_ff && can_load;
   assign req_chan.ready = !a_valid_ff || can_load;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      a_valid_in = a_valid_ff;
      a_byte_in  = a_byte_ff;
      a_eoi_in   = a_eoi_ff;
      if (req_take) begin
         a_valid_in = 1'b1;
         a_byte_in  = req_chan.in_byte;
         a_eoi_in   = req_chan.end_of_input;
      end else if (a_move) begin
         a_valid_in = 1'b0;
      end
   end

   fqt_decode #(
      .CNT_W (CNT_W)
   ) u_decode (
      .in_byte      (a_byte_ff),
      .end_of_input (a_eoi_ff),
      .cookie_mode  (cookie_ff),
      .stop_mode    (stop_ff),
      .limit        (lim_ff),
      .st           (st_ff),
      .count        (count_ff),
      .st_next      (st_next),
      .count_next   (count_next),
      .res          (dec_res),
      .res_cnt      (dec_cnt)
   );

   // state advances only when the byte's results are committed
   assign st_in    = a_move ? st_next    : st_ff;
   assign count_in = a_move ? count_next : count_ff;

   fqt_burst u_burst (
      .clock    (clock),
      .reset    (reset),
      .load     (a_move),
      .load_res (dec_res),
      .load_cnt (dec_cnt),
      .can_load (can_load),
      .rsp_chan (rsp_chan)
   );

   always_ff @(posedge clock) begin
      a_byte_ff <= a_byte_in;
      a_eoi_ff  <= a_eoi_in;
      if (reset) begin
         cookie_ff  <= 1'b0;
         stop_ff    <= 1'b0;
         lim_ff     <= CNT_W'(LIM_RESET);
         a_valid_ff <= 1'b0;
         st_ff      <= '0;
         count_ff   <= '0;
      end else begin
         cookie_ff  <= cookie_in;
         stop_ff    <= stop_in;
         lim_ff     <= lim_in;
         a_valid_ff <= a_valid_in;
         st_ff      <= st_in;
         count_ff   <= count_in;
      end
   end

   // a stalled byte in the input register holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !can_load |=> a_valid_ff && $stable(a_byte_ff) && $stable(a_eoi_ff))
      else $error("input register lost a stalled byte");

   // end of input always leaves a clean key state
   eoi_clear: assert property (@(posedge clock) disable iff (reset)
      a_move && a_eoi_ff |=> !st_ff.in_value && count_ff == '0 &&
                             st_ff.phase == fqt_pkg::ESC_NONE)
      else $error("parse state not cleared at end of input");

   // end of input always produces at least its end marker
   eoi_marker: assert property (@(posedge clock) disable iff (reset)
      a_move && a_eoi_ff |=> rsp_chan.valid)
      else $error("end of input gave no result");

endmodule

`default_nettype wire
